[src/rvals_pkg.sv]
`default_nettype none
package rvals_pkg;

  localparam int XLEN      = 32;
  localparam int IMM_W     = 12;
  localparam int OP_W      = 3;
  localparam int REG_COUNT = 32;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int MEM_IDX_W = 10;
  localparam int MEM_WORDS = 1 << MEM_IDX_W;

  typedef logic [OP_W-1:0]      op_t;
  typedef logic [XLEN-1:0]      word_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic [MEM_IDX_W-1:0] mem_idx_t;

  localparam op_t OP_ADD  = 3'd0;
  localparam op_t OP_ADDI = 3'd1;
  localparam op_t OP_SW   = 3'd2;
  localparam op_t OP_LW   = 3'd3;

endpackage
`default_nettype wire

[src/rv_add_load_store_core.sv]
`default_nettype none
// Executes one decoded ADD, ADDI, SW or LW request per handshake against a
// 32-entry register file and a MEM_WORDS-word data memory, both held in
// synchronous memories with registered read data. ADD, ADDI, SW and
// unrecognized requests sustain one request per cycle while out_ready is
// high; an LW holds off the next request until its data memory read is
// done, so that the next request can read its destination as it is
// written back. A result passes the request stage (and for LW the
// write-back stage) into an output register that holds it; while a result
// waits, one more request is taken, then in_ready drops until it is accepted.
// After reset the data memory is cleared one word per cycle, and in_ready
// stays low until all MEM_WORDS words (1024 by default) are cleared.
module rv_add_load_store_core
  import rvals_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [OP_W-1:0]         in_req_type,
  input  wire  [REG_IDX_W-1:0]    in_dest_reg,
  input  wire  [REG_IDX_W-1:0]    in_src1_reg,
  input  wire  [REG_IDX_W-1:0]    in_src2_reg,
  input  wire  signed [IMM_W-1:0] in_immediate,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic                    out_accepted,
  output logic signed [XLEN-1:0]  out_result_value,
  output logic signed [XLEN-1:0]  out_effective_address
);

  word_t    rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;
  word_t    dm_mem [MEM_WORDS];

  logic     clr_busy_r;
  mem_idx_t clr_idx_r;

  logic     s1_vld_r;
  op_t      s1_op_r;
  reg_idx_t s1_rd_r;
  logic [IMM_W-1:0] s1_imm_r;
  word_t    rf_a_r;
  word_t    rf_b_r;

  logic     s2_vld_r;
  reg_idx_t s2_rd_r;
  word_t    s2_ea_r;
  word_t    dm_rdata_r;

  logic     out_vld_r;
  logic     out_acc_r;
  word_t    out_val_r;
  word_t    out_ea_r;
  logic     out_acc_nxt;
  word_t    out_val_nxt;
  word_t    out_ea_nxt;

  logic     in_acc;
  logic     out_free;
  logic     s1_known;
  logic     s1_is_lw;
  logic     s1_go;
  logic     s2_go;
  word_t    s1_opnd;
  word_t    s1_sum;
  mem_idx_t s1_widx;
  reg_idx_t rd_addr_a;
  reg_idx_t rd_addr_b;
  logic     rf_we;
  reg_idx_t rf_waddr;
  word_t    rf_wdata;

  assign out_free = !out_vld_r || out_ready;
  assign s1_is_lw = s1_op_r == OP_LW;
  assign s1_go    = s1_vld_r && (s1_is_lw || out_free);
  assign s2_go    = s2_vld_r && out_free;

  assign in_ready = !clr_busy_r && !(s1_vld_r && s1_is_lw) &&
                    (!s1_vld_r || s1_go) && (!s2_vld_r || s2_go);
  assign in_acc   = in_valid && in_ready;

  assign rd_addr_a = in_src1_reg;
  assign rd_addr_b = (in_req_type == OP_SW) ? in_dest_reg : in_src2_reg;

  always_comb begin
    s1_known = s1_op_r inside {OP_ADD, OP_ADDI, OP_SW, OP_LW};
    s1_opnd  = (s1_op_r == OP_ADD) ? rf_b_r
               : {{(XLEN-IMM_W){s1_imm_r[IMM_W-1]}}, s1_imm_r};
    s1_sum   = rf_a_r + s1_opnd;
    s1_widx  = s1_sum[MEM_IDX_W+1:2];
  end

  always_comb begin
    rf_we    = s2_go || (s1_go && (s1_op_r == OP_ADD || s1_op_r == OP_ADDI));
    rf_waddr = s2_vld_r ? s2_rd_r : s1_rd_r;
    rf_wdata = s2_vld_r ? dm_rdata_r : s1_sum;
  end

  // Register file: reads are captured at acceptance, with a write landing
  // on the same edge forwarded into the captured operand.
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (in_acc) begin
      if (rf_we && rf_waddr == rd_addr_a) begin
        rf_a_r <= rf_wdata;
      end else if (rf_vld_r[rd_addr_a]) begin
        rf_a_r <= rf_mem[rd_addr_a];
      end else begin
        rf_a_r <= {{(XLEN-REG_IDX_W){1'b0}}, rd_addr_a};
      end
      if (rf_we && rf_waddr == rd_addr_b) begin
        rf_b_r <= rf_wdata;
      end else if (rf_vld_r[rd_addr_b]) begin
        rf_b_r <= rf_mem[rd_addr_b];
      end else begin
        rf_b_r <= {{(XLEN-REG_IDX_W){1'b0}}, rd_addr_b};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[rf_waddr] <= 1'b1;
    end
  end

  // Data memory: one write port shared by the clearing pass and stores.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      dm_mem[clr_idx_r] <= '0;
    end else if (s1_go && s1_op_r == OP_SW) begin
      dm_mem[s1_widx] <= rf_b_r;
    end
    if (s1_go && s1_is_lw) begin
      dm_rdata_r <= dm_mem[s1_widx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == mem_idx_t'(MEM_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_go && s1_is_lw) begin
        s2_vld_r <= 1'b1;
      end else if (s2_go) begin
        s2_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_req_type;
      s1_rd_r  <= in_dest_reg;
      s1_imm_r <= in_immediate;
    end
    if (s1_go && s1_is_lw) begin
      s2_rd_r <= s1_rd_r;
      s2_ea_r <= s1_sum;
    end
  end

  always_comb begin
    if (s2_vld_r) begin
      out_acc_nxt = 1'b1;
      out_val_nxt = dm_rdata_r;
      out_ea_nxt  = s2_ea_r;
    end else begin
      out_acc_nxt = s1_known;
      out_val_nxt = '0;
      out_ea_nxt  = '0;
      case (s1_op_r)
        OP_ADD, OP_ADDI: begin
          out_val_nxt = s1_sum;
        end
        OP_SW: begin
          out_val_nxt = rf_b_r;
          out_ea_nxt  = s1_sum;
        end
        default: begin
          out_val_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s2_go || (s1_go && !s1_is_lw)) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go || (s1_go && !s1_is_lw)) begin
      out_acc_r <= out_acc_nxt;
      out_val_r <= out_val_nxt;
      out_ea_r  <= out_ea_nxt;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_accepted          = out_acc_r;
  assign out_result_value      = $signed(out_val_r);
  assign out_effective_address = $signed(out_ea_r);

`ifndef SYNTHESIS
  a_single_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_vld_r && s2_vld_r))
    else $error("Two requests are in flight at once.");

  a_lw_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_op_r == OP_LW |=> s2_vld_r && !s1_vld_r)
    else $error("A load did not move to the write-back stage.");

  a_s2_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s2_vld_r) |-> $past(s1_vld_r && s1_op_r == OP_LW))
    else $error("The write-back stage filled without a load.");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("A request was offered readiness during the clearing pass.");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_val_r == '0 && out_ea_r == '0)
    else $error("A rejected request carries nonzero result fields.");
`endif

endmodule
`default_nettype wire
